// File: hw/rtl/joyc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// joyc_pkg: shared types and constants of the joystick state conditioner
// Sizes of the per-index state, the state entry layout, command and register
// codes, and the configuration register bundle.
// ----------------------------------------------------------------------------
package joyc_pkg;

  // Per-class index counts
  localparam int NUM_AXES    = 8;
  localparam int NUM_BUTTONS = 32;
  localparam int NUM_HATS    = 4;
  localparam int NUM_BALLS   = 4;

  // One state memory covers the largest index space
  localparam int MAX_AB    = (NUM_AXES > NUM_BUTTONS) ? NUM_AXES : NUM_BUTTONS;
  localparam int MAX_HB    = (NUM_HATS > NUM_BALLS) ? NUM_HATS : NUM_BALLS;
  localparam int MEM_DEPTH = (MAX_AB > MAX_HB) ? MAX_AB : MAX_HB;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // Command codes
  localparam logic [2:0] CMD_AXIS     = 3'd0;
  localparam logic [2:0] CMD_BTN_DOWN = 3'd1;
  localparam logic [2:0] CMD_BTN_UP   = 3'd2;
  localparam logic [2:0] CMD_HAT      = 3'd3;
  localparam logic [2:0] CMD_BALL     = 3'd4;
  localparam logic [2:0] CMD_CLEAR    = 3'd5;
  localparam logic [2:0] CMD_QUERY    = 3'd6;

  // Configuration register indexes
  localparam int CFG_W     = 21;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_EDGE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH   = 3'd4;

  // Q2.16 full scale
  localparam logic [16:0] Q_ONE = 17'd65536;

  typedef struct packed {
    logic [16:0]        dead_zone;
    logic [16:0]        dead_edge;
    logic [20:0]        range_gain;
    logic signed [15:0] out_low;
    logic signed [15:0] out_high;
  } joyc_cfg_t;

  // One state memory word: everything kept for one index
  typedef struct packed {
    logic               seen;
    logic signed [15:0] raw;
    logic               button;
    logic [3:0]         hat;
    logic [31:0]        ball_x;
    logic [31:0]        ball_y;
  } joyc_entry_t;

endpackage : joyc_pkg
`default_nettype wire

// File: hw/rtl/joyc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// joyc_in_if: event channel
// Valid/ready channel carrying one joystick event per beat.
// ----------------------------------------------------------------------------
interface joyc_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [7:0]         index;
  logic signed [15:0] axis_sample;
  logic [3:0]         hat_code;
  logic signed [15:0] ball_dx;
  logic signed [15:0] ball_dy;

  modport source (output valid, command, index, axis_sample, hat_code, ball_dx, ball_dy,
                  input ready);
  modport sink   (input valid, command, index, axis_sample, hat_code, ball_dx, ball_dy,
                  output ready);
endinterface : joyc_in_if
`default_nettype wire

// File: hw/rtl/joyc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// joyc_out_if: state report channel
// Valid/ready channel carrying the reported state of one index per beat.
// ----------------------------------------------------------------------------
interface joyc_out_if;
  logic               valid;
  logic               ready;
  logic               axis_known;
  logic signed [17:0] axis_level;
  logic signed [15:0] axis_mapped;
  logic               button_down;
  logic [3:0]         hat_state;
  logic signed [31:0] ball_x_total;
  logic signed [31:0] ball_y_total;

  modport source (output valid, axis_known, axis_level, axis_mapped, button_down,
                  hat_state, ball_x_total, ball_y_total, input ready);
  modport sink   (input valid, axis_known, axis_level, axis_mapped, button_down,
                  hat_state, ball_x_total, ball_y_total, output ready);
endinterface : joyc_out_if
`default_nettype wire

// File: hw/rtl/joystick_state_deadzone_conditioner_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// joystick_state_deadzone_conditioner_unit: joystick state keeper
// Applies axis, button, hat, ball, clear and query events to per-index state
// and reports the full state of the addressed index with the axis conditioned.
// ----------------------------------------------------------------------------
// Each accepted event yields exactly one report beat. Events are handled one
// at a time: read of the state memory, modify and write back, then the
// five-stage axis pipeline with its two multipliers. The next event can be
// taken the cycle after the report enters the output register, which may
// still hold it while the next event is at work. State lives in one
// MEM_DEPTH-entry memory with a valid flag per entry; reset and the clear
// command drop all flags at once, so there is no clearing pass.
// The user must write configuration through cfg_we/cfg_idx/cfg_data only
// while idle; the block itself does not enforce it.
module joystick_state_deadzone_conditioner_unit
  import joyc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  joyc_in_if.sink                   in_ch,
  joyc_out_if.source                out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RMW  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  joyc_cfg_t          cfg_r, cfg_nxt;

  joyc_entry_t        mem [MEM_DEPTH];
  joyc_entry_t        rd_data_r;
  logic [MEM_DEPTH-1:0] ent_vld_r, ent_vld_nxt;

  // Event beat held while it is worked on
  logic [2:0]         cmd_r;
  logic [7:0]         idx_r;
  logic signed [15:0] sample_r;
  logic [3:0]         hat_r;
  logic signed [15:0] dx_r, dy_r;

  // Updated entry and range flags
  joyc_entry_t        item_r;
  logic               ax_ok_r, bt_ok_r, ht_ok_r, bl_ok_r;
  logic               ax_start_r;

  // Output register
  logic               out_vld_r, out_vld_nxt;
  logic               o_known_r;
  logic signed [17:0] o_level_r;
  logic signed [15:0] o_mapped_r;
  logic               o_btn_r;
  logic [3:0]         o_hat_r;
  logic [31:0]        o_bx_r, o_by_r;

  logic               in_acc, out_free, out_load;
  logic [ADDR_W-1:0]  addr_r;
  logic               ax_ok, bt_ok, ht_ok, bl_ok, mem_ok;
  joyc_entry_t        cur_s, new_s;
  logic               wr_en;

  logic               ax_done;
  logic signed [17:0] ax_level;
  logic signed [15:0] ax_mapped;

  assign in_ch.ready = rst_n && (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_vld_r || out_ch.ready;
  assign out_load    = (state_r == ST_OUT) && out_free;
  assign addr_r      = idx_r[ADDR_W-1:0];

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_DEAD_ZONE:  cfg_nxt.dead_zone  = cfg_data[16:0];
        REG_DEAD_EDGE:  cfg_nxt.dead_edge  = cfg_data[16:0];
        REG_RANGE_GAIN: cfg_nxt.range_gain = cfg_data[20:0];
        REG_OUT_LOW:    cfg_nxt.out_low    = $signed(cfg_data[15:0]);
        REG_OUT_HIGH:   cfg_nxt.out_high   = $signed(cfg_data[15:0]);
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_RMW;
      ST_RMW:  state_nxt = ST_WAIT;
      ST_WAIT: if (ax_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Range checks on the held index
  always_comb begin
    ax_ok  = {1'b0, idx_r} < 9'(NUM_AXES);
    bt_ok  = {1'b0, idx_r} < 9'(NUM_BUTTONS);
    ht_ok  = {1'b0, idx_r} < 9'(NUM_HATS);
    bl_ok  = {1'b0, idx_r} < 9'(NUM_BALLS);
    mem_ok = {1'b0, idx_r} < 9'(MEM_DEPTH);
  end

  // Modify the entry read back from the state memory
  always_comb begin
    cur_s       = (mem_ok && ent_vld_r[addr_r]) ? rd_data_r : '0;
    new_s       = cur_s;
    ent_vld_nxt = ent_vld_r;
    wr_en       = 1'b0;
    if (state_r == ST_RMW) begin
      unique case (cmd_r)
        CMD_AXIS: if (ax_ok) begin
          new_s.raw  = sample_r;
          new_s.seen = 1'b1;
        end
        CMD_BTN_DOWN: if (bt_ok) new_s.button = 1'b1;
        CMD_BTN_UP:   if (bt_ok) new_s.button = 1'b0;
        CMD_HAT:      if (ht_ok) new_s.hat = hat_r;
        CMD_BALL: if (bl_ok) begin
          new_s.ball_x = cur_s.ball_x + 32'(dx_r);
          new_s.ball_y = cur_s.ball_y + 32'(dy_r);
        end
        CMD_CLEAR: new_s = '0;
        default:   new_s = cur_s;
      endcase
      if (cmd_r == CMD_CLEAR) begin
        ent_vld_nxt = '0;
      end else if (mem_ok) begin
        wr_en               = 1'b1;
        ent_vld_nxt[addr_r] = 1'b1;
      end
    end
  end

  // Output register handshake
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_load)          out_vld_nxt = 1'b1;
    else if (out_ch.ready) out_vld_nxt = 1'b0;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ent_vld_r  <= '0;
      out_vld_r  <= 1'b0;
      ax_start_r <= 1'b0;
      cfg_r      <= '{dead_zone: 17'd0, dead_edge: 17'd0, range_gain: 21'd65536,
                      out_low: -16'sd32768, out_high: 16'sd32767};
    end else begin
      state_r    <= state_nxt;
      ent_vld_r  <= ent_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      ax_start_r <= (state_r == ST_RMW);
      cfg_r      <= cfg_nxt;
    end
  end

  // State memory: read at accept, write back in the cycle after
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= mem[in_ch.index[ADDR_W-1:0]];
    end
    if (wr_en) begin
      mem[addr_r] <= new_s;
    end
  end

  // Hold the event beat and the updated entry
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= in_ch.command;
      idx_r    <= in_ch.index;
      sample_r <= in_ch.axis_sample;
      hat_r    <= in_ch.hat_code;
      dx_r     <= in_ch.ball_dx;
      dy_r     <= in_ch.ball_dy;
    end
    if (state_r == ST_RMW) begin
      item_r  <= new_s;
      ax_ok_r <= ax_ok;
      bt_ok_r <= bt_ok;
      ht_ok_r <= ht_ok;
      bl_ok_r <= bl_ok;
    end
  end

  joyc_axis u_axis (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ax_start_r),
    .raw    (item_r.raw),
    .cfg    (cfg_r),
    .done   (ax_done),
    .level  (ax_level),
    .mapped (ax_mapped)
  );

  // Load the report beat
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_known_r  <= ax_ok_r && item_r.seen;
      o_level_r  <= (ax_ok_r && item_r.seen) ? ax_level : 18'sd0;
      o_mapped_r <= (ax_ok_r && item_r.seen) ? ax_mapped : 16'sd0;
      o_btn_r    <= bt_ok_r && item_r.button;
      o_hat_r    <= ht_ok_r ? item_r.hat : 4'd0;
      o_bx_r     <= bl_ok_r ? item_r.ball_x : 32'd0;
      o_by_r     <= bl_ok_r ? item_r.ball_y : 32'd0;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.axis_known   = o_known_r;
  assign out_ch.axis_level   = o_level_r;
  assign out_ch.axis_mapped  = o_mapped_r;
  assign out_ch.button_down  = o_btn_r;
  assign out_ch.hat_state    = o_hat_r;
  assign out_ch.ball_x_total = $signed(o_bx_r);
  assign out_ch.ball_y_total = $signed(o_by_r);

`ifndef SYNTH
  // An accepted beat goes straight to the read-modify-write step
  a_acc_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_RMW))
    else $error("event accept not followed by state update");

  // The axis pipeline only finishes while its result is awaited
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ax_done |-> (state_r == ST_WAIT))
    else $error("axis result outside wait state");

  // A clear command drops every entry
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RMW && cmd_r == CMD_CLEAR) |=> (ent_vld_r == '0))
    else $error("clear left entries valid");

  // A report loaded into a free output register is presented
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_vld_r)
    else $error("loaded report not presented");
`endif

endmodule : joystick_state_deadzone_conditioner_unit
`default_nettype wire

// File: hw/rtl/joyc_axis.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// joyc_axis: axis conditioning pipeline
// Five-stage pipeline: normalize and classify, gain multiply, round and
// saturate, range multiply, offset. Results hold until the next start reaches the last stage.
// ----------------------------------------------------------------------------
module joyc_axis
  import joyc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [15:0] raw,
  input  wire joyc_cfg_t          cfg,
  output logic                    done,
  output logic signed [17:0]      level,
  output logic signed [15:0]      mapped
);

  localparam logic [1:0] CLS_ZERO  = 2'd0;
  localparam logic [1:0] CLS_POS   = 2'd1;
  localparam logic [1:0] CLS_NEG   = 2'd2;
  localparam logic [1:0] CLS_SCALE = 2'd3;

  logic [4:0]         vld_r;
  logic [1:0]         cls1_r, cls2_r;
  logic               neg1_r, neg2_r;
  logic [16:0]        mdz1_r;
  logic [37:0]        prod2_r;
  logic signed [17:0] lvl3_r, lvl4_r, lvl5_r;
  logic signed [35:0] mprod4_r;
  logic signed [15:0] map5_r;

  // Stage 1 terms
  logic signed [17:0] n_s;
  logic [16:0]        mag_s;
  logic signed [19:0] hi_s, lo_s;
  logic [1:0]         cls_s;

  // Stage 3 terms
  logic [38:0]        rnd_s;
  logic [22:0]        p_s;
  logic [16:0]        sat_s;
  logic signed [17:0] lvl_s;

  // Stage 4 and 5 terms
  logic signed [16:0] d_s;
  logic [17:0]        t_s;
  logic signed [35:0] pm_s;
  logic signed [18:0] q_s;

  // Normalize to Q2.16 and classify against the deadzone and edge margin
  always_comb begin
    n_s   = $signed({raw[15], raw, 1'b0}) + $signed({17'd0, !raw[15] && raw[14]});
    mag_s = n_s[17] ? 17'(-n_s) : 17'(n_s);
    hi_s  = 20'(n_s) + 20'($signed({3'b000, cfg.dead_edge}));
    lo_s  = 20'(n_s) - 20'($signed({3'b000, cfg.dead_edge}));
    priority if (mag_s < cfg.dead_zone) cls_s = CLS_ZERO;
    else if (hi_s > 20'sd65536)         cls_s = CLS_POS;
    else if (lo_s < -20'sd65536)        cls_s = CLS_NEG;
    else                                cls_s = CLS_SCALE;
  end

  // Round half up, saturate to full scale, restore sign
  always_comb begin
    rnd_s = {1'b0, prod2_r} + 39'd32768;
    p_s   = rnd_s[38:16];
    sat_s = (p_s > 23'(Q_ONE)) ? Q_ONE : p_s[16:0];
    unique case (cls2_r)
      CLS_ZERO:  lvl_s = 18'sd0;
      CLS_POS:   lvl_s = 18'sd65536;
      CLS_NEG:   lvl_s = -18'sd65536;
      CLS_SCALE: lvl_s = neg2_r ? -$signed({1'b0, sat_s}) : $signed({1'b0, sat_s});
      default:   lvl_s = 18'sd0;
    endcase
  end

  // Map terms: span times offset level, then divide by 2^17 rounding half up
  always_comb begin
    d_s  = 17'(cfg.out_high) - 17'(cfg.out_low);
    t_s  = 18'(lvl3_r + 18'sd65536);
    pm_s = mprod4_r + 36'sd65536;
    q_s  = 19'(pm_s >>> 17);
  end

  // Advance the stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], start};
    end
  end

  // Pipeline data
  always_ff @(posedge clk) begin
    if (start) begin
      cls1_r <= cls_s;
      neg1_r <= n_s[17];
      mdz1_r <= mag_s - cfg.dead_zone;
    end
    if (vld_r[0]) begin
      prod2_r <= 38'(mdz1_r) * 38'(cfg.range_gain);
      cls2_r  <= cls1_r;
      neg2_r  <= neg1_r;
    end
    if (vld_r[1]) begin
      lvl3_r <= lvl_s;
    end
    if (vld_r[2]) begin
      mprod4_r <= 36'(d_s) * 36'($signed({1'b0, t_s}));
      lvl4_r   <= lvl3_r;
    end
    if (vld_r[3]) begin
      map5_r <= cfg.out_low + q_s[15:0];
      lvl5_r <= lvl4_r;
    end
  end

  assign done   = vld_r[4];
  assign level  = lvl5_r;
  assign mapped = map5_r;

endmodule : joyc_axis
`default_nettype wire
